// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rtch_pkg.sv -----
`timescale 1ns / 1ps
package rtch_pkg;

  localparam int XW  = 32;
  localparam int TW  = 31;
  localparam int CIW = 3;

  localparam logic [TW-1:0] T_NONE = {TW{1'b1}};

  typedef enum logic [CIW-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_DIR_X    = 3'd3,
    CFG_DIR_Y    = 3'd4,
    CFG_DIR_Z    = 3'd5
  } cfg_idx_t;

  function automatic logic signed [XW-1:0] sat33(input logic signed [XW:0] x);
    logic signed [XW-1:0] r;
    if (x[XW] != x[XW-1]) begin
      r = x[XW] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
    end else begin
      r = x[XW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [XW-1:0] sat64(input logic signed [63:0] x);
    logic signed [XW-1:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = {1'b0, {(XW-1){1'b1}}};
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = {1'b1, {(XW-1){1'b0}}};
    end else begin
      r = x[XW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/rtch_if.sv -----
`timescale 1ns / 1ps
interface rtch_tri_if;
  logic valid;
  logic ready;
  logic signed [rtch_pkg::XW-1:0] a_x, a_y, a_z;
  logic signed [rtch_pkg::XW-1:0] b_x, b_y, b_z;
  logic signed [rtch_pkg::XW-1:0] c_x, c_y, c_z;
  logic final_tri;
  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, final_tri,
                 input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, final_tri,
               output ready);
endinterface

interface rtch_hit_if;
  logic valid;
  logic ready;
  logic found;
  logic [rtch_pkg::TW-1:0] nearest_t;
  modport source(output valid, found, nearest_t, input ready);
  modport sink(input valid, found, nearest_t, output ready);
endinterface

interface rtch_cfg_if;
  logic valid;
  logic ready;
  logic [rtch_pkg::CIW-1:0] index;
  logic [rtch_pkg::XW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/ray_triangle_closest_hit.sv -----
`timescale 1ns / 1ps
// Up to 24 products through one shared 32x32 multiplier, each product registered in
// ST_MUL and accumulated in ST_ACC, plus up to three serial divisions (ST_DIV), each
// followed by one check state (ST_CHK), and a final state (ST_FIN) per triangle.
// Throughput: one triangle at a time; parallel or outside triangles exit early.
// Reset (synchronous, rst_n low): origin 0, direction (0,0,-1.0), no hit, idle.
module ray_triangle_closest_hit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rtch_tri_if.sink    in_tri,
  rtch_hit_if.source  out_hit,
  rtch_cfg_if.sink    cfg_wr
);

  localparam int XW = rtch_pkg::XW;
  localparam int TW = rtch_pkg::TW;
  localparam int QW = XW + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  localparam logic [4:0] OP_A_LAST = 5'd8;
  localparam logic [4:0] OP_U_LAST = 5'd11;
  localparam logic [4:0] OP_V_LAST = 5'd20;
  localparam logic [4:0] OP_T_LAST = 5'd23;

  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] TNONE_Q = QW'(rtch_pkg::T_NONE);
  localparam logic signed [XW-1:0] ONE32 = XW'(1) << FRAC_BITS;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_CHK  = 6'b010000,
    ST_FIN  = 6'b100000
  } st_t;

  st_t st_r, st_nxt;

  logic signed [XW-1:0] org_r [3];
  logic signed [XW-1:0] dir_r [3];
  logic signed [XW-1:0] s_r [3], e1_r [3], e2_r [3], h_r [3], q_r [3];
  logic signed [XW-1:0] a_r;
  logic fin_r;
  logic [4:0] op_r;
  logic signed [63:0] prod_r, acc_r;
  logic [XW-1:0] dmag_r;
  logic [XW-1:0] rem_r;
  logic [QW-1:0] dvd_r;
  logic neg_r;
  logic [CW-1:0] cnt_r;
  logic [FRAC_BITS:0] u_r;
  logic [TW-1:0] best_r;
  logic any_r;
  logic out_valid_r, found_r;
  logic [TW-1:0] nearest_r;

  logic signed [XW-1:0] va [3], vb [3], vc [3];
  logic in_acc;
  logic signed [XW-1:0] opa, opb;
  logic op_first, op_sub, op_last;
  logic signed [63:0] term, acc_nxt;
  logic signed [XW-1:0] acc_sat;
  logic [XW:0] rem_sh;
  logic rem_ge;
  logic qneg, qnz;
  logic [QW:0] uv_sum;
  logic [TW-1:0] t_sat;
  logic out_free;

  assign va[0] = in_tri.a_x; assign va[1] = in_tri.a_y; assign va[2] = in_tri.a_z;
  assign vb[0] = in_tri.b_x; assign vb[1] = in_tri.b_y; assign vb[2] = in_tri.b_z;
  assign vc[0] = in_tri.c_x; assign vc[1] = in_tri.c_y; assign vc[2] = in_tri.c_z;

  assign in_tri.ready = (st_r == ST_IDLE);
  assign in_acc = in_tri.valid && in_tri.ready;
  assign cfg_wr.ready = 1'b1;

  assign out_hit.valid = out_valid_r;
  assign out_hit.found = found_r;
  assign out_hit.nearest_t = nearest_r;
  assign out_free = !out_valid_r || out_hit.ready;

  // operand select for the shared multiplier
  always_comb begin
    opa = dir_r[1];
    opb = e2_r[2];
    case (op_r)
      5'd0:  begin opa = dir_r[1]; opb = e2_r[2]; end
      5'd1:  begin opa = dir_r[2]; opb = e2_r[1]; end
      5'd2:  begin opa = dir_r[2]; opb = e2_r[0]; end
      5'd3:  begin opa = dir_r[0]; opb = e2_r[2]; end
      5'd4:  begin opa = dir_r[0]; opb = e2_r[1]; end
      5'd5:  begin opa = dir_r[1]; opb = e2_r[0]; end
      5'd6:  begin opa = e1_r[0];  opb = h_r[0];  end
      5'd7:  begin opa = e1_r[1];  opb = h_r[1];  end
      5'd8:  begin opa = e1_r[2];  opb = h_r[2];  end
      5'd9:  begin opa = s_r[0];   opb = h_r[0];  end
      5'd10: begin opa = s_r[1];   opb = h_r[1];  end
      5'd11: begin opa = s_r[2];   opb = h_r[2];  end
      5'd12: begin opa = s_r[1];   opb = e1_r[2]; end
      5'd13: begin opa = s_r[2];   opb = e1_r[1]; end
      5'd14: begin opa = s_r[2];   opb = e1_r[0]; end
      5'd15: begin opa = s_r[0];   opb = e1_r[2]; end
      5'd16: begin opa = s_r[0];   opb = e1_r[1]; end
      5'd17: begin opa = s_r[1];   opb = e1_r[0]; end
      5'd18: begin opa = dir_r[0]; opb = q_r[0];  end
      5'd19: begin opa = dir_r[1]; opb = q_r[1];  end
      5'd20: begin opa = dir_r[2]; opb = q_r[2];  end
      5'd21: begin opa = e2_r[0];  opb = q_r[0];  end
      5'd22: begin opa = e2_r[1];  opb = q_r[1];  end
      5'd23: begin opa = e2_r[2];  opb = q_r[2];  end
      default: begin opa = dir_r[1]; opb = e2_r[2]; end
    endcase
  end

  assign op_first = op_r inside {5'd0, 5'd2, 5'd4, 5'd6, 5'd9, 5'd12, 5'd14, 5'd16,
                                 5'd18, 5'd21};
  assign op_sub   = op_r inside {5'd1, 5'd3, 5'd5, 5'd13, 5'd15, 5'd17};
  assign op_last  = op_r inside {5'd1, 5'd3, 5'd5, 5'd8, 5'd11, 5'd13, 5'd15, 5'd17,
                                 5'd20, 5'd23};

  assign term    = prod_r >>> FRAC_BITS;
  assign acc_nxt = (op_first ? 64'sd0 : acc_r) + (op_sub ? -term : term);
  assign acc_sat = rtch_pkg::sat64(acc_nxt);

  assign rem_sh = {rem_r, dvd_r[QW-1]};
  assign rem_ge = rem_sh >= {1'b0, dmag_r};

  assign qnz    = |dvd_r;
  assign qneg   = neg_r && qnz;
  assign uv_sum = {1'b0, dvd_r} + (QW+1)'(u_r);
  assign t_sat  = (dvd_r > TNONE_Q) ? rtch_pkg::T_NONE : dvd_r[TW-1:0];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_ACC;
      ST_ACC: begin
        if (op_r == OP_A_LAST && acc_sat == '0) begin
          st_nxt = ST_FIN;
        end else if (op_r == OP_U_LAST || op_r == OP_V_LAST || op_r == OP_T_LAST) begin
          st_nxt = ST_DIV;
        end else begin
          st_nxt = ST_MUL;
        end
      end
      ST_DIV:  if (cnt_r == CW'(1)) st_nxt = ST_CHK;
      ST_CHK: begin
        if (op_r == OP_U_LAST) begin
          st_nxt = (!qneg && dvd_r <= ONE_Q) ? ST_MUL : ST_FIN;
        end else if (op_r == OP_V_LAST) begin
          st_nxt = (!qneg && uv_sum <= {1'b0, ONE_Q}) ? ST_MUL : ST_FIN;
        end else begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN:  if (!fin_r || out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      org_r[0] <= '0; org_r[1] <= '0; org_r[2] <= '0;
      dir_r[0] <= '0; dir_r[1] <= '0; dir_r[2] <= -ONE32;
      best_r <= rtch_pkg::T_NONE;
      any_r <= 1'b0;
      out_valid_r <= 1'b0;
      op_r <= '0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.index)
          rtch_pkg::CFG_ORIGIN_X: org_r[0] <= cfg_wr.data;
          rtch_pkg::CFG_ORIGIN_Y: org_r[1] <= cfg_wr.data;
          rtch_pkg::CFG_ORIGIN_Z: org_r[2] <= cfg_wr.data;
          rtch_pkg::CFG_DIR_X:    dir_r[0] <= cfg_wr.data;
          rtch_pkg::CFG_DIR_Y:    dir_r[1] <= cfg_wr.data;
          rtch_pkg::CFG_DIR_Z:    dir_r[2] <= cfg_wr.data;
          default: ;
        endcase
      end
      if (st_r == ST_FIN && fin_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_hit.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: if (in_acc) op_r <= '0;
        ST_ACC: begin
          if (st_nxt == ST_DIV) begin
            cnt_r <= CW'(QW);
          end else begin
            op_r <= op_r + 5'd1;
          end
        end
        ST_DIV: cnt_r <= cnt_r - CW'(1);
        ST_CHK: begin
          op_r <= op_r + 5'd1;
          if (op_r == OP_T_LAST && !neg_r && qnz && t_sat < best_r) begin
            best_r <= t_sat;
            any_r <= 1'b1;
          end
        end
        ST_FIN: if (fin_r && out_free) begin
          best_r <= rtch_pkg::T_NONE;
          any_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fin_r <= in_tri.final_tri;
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= rtch_pkg::sat33({vb[i][XW-1], vb[i]} - {va[i][XW-1], va[i]});
        e2_r[i] <= rtch_pkg::sat33({vc[i][XW-1], vc[i]} - {va[i][XW-1], va[i]});
        s_r[i]  <= rtch_pkg::sat33({org_r[i][XW-1], org_r[i]} - {va[i][XW-1], va[i]});
      end
    end
    if (st_r == ST_MUL) prod_r <= opa * opb;
    if (st_r == ST_ACC) begin
      acc_r <= acc_nxt;
      if (op_last) begin
        case (op_r)
          5'd1:  h_r[0] <= acc_sat;
          5'd3:  h_r[1] <= acc_sat;
          5'd5:  h_r[2] <= acc_sat;
          5'd13: q_r[0] <= acc_sat;
          5'd15: q_r[1] <= acc_sat;
          5'd17: q_r[2] <= acc_sat;
          OP_A_LAST: begin
            a_r <= acc_sat;
            dmag_r <= acc_sat[XW-1] ? XW'(-acc_sat) : XW'(acc_sat);
          end
          default: begin
            neg_r <= acc_sat[XW-1] ^ a_r[XW-1];
            rem_r <= '0;
            dvd_r <= {(acc_sat[XW-1] ? XW'(-acc_sat) : XW'(acc_sat)),
                      {FRAC_BITS{1'b0}}};
          end
        endcase
      end
    end
    if (st_r == ST_DIV) begin
      rem_r <= rem_ge ? XW'(rem_sh - {1'b0, dmag_r}) : rem_sh[XW-1:0];
      dvd_r <= {dvd_r[QW-2:0], rem_ge};
    end
    if (st_r == ST_CHK && op_r == OP_U_LAST) u_r <= dvd_r[FRAC_BITS:0];
    if (st_r == ST_FIN && fin_r && out_free) begin
      found_r <= any_r;
      nearest_r <= any_r ? best_r : rtch_pkg::T_NONE;
    end
  end

endmodule

// ----- sv/rtch_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtch_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic found,
  input logic [rtch_pkg::TW-1:0] nearest_t,
  input logic cfg_ready
);

  `ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after request")
  `ASSERT_IMPL(a_miss_code, out_valid && !found, nearest_t == rtch_pkg::T_NONE, "miss t")
  `ASSERT_IMPL(a_hit_code, out_valid && found, nearest_t != rtch_pkg::T_NONE, "hit t")
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `ASSERT_IMPL(a_cfg_ready, 1'b1, cfg_ready, "cfg not ready")

endmodule

bind ray_triangle_closest_hit rtch_chk u_rtch_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_tri.valid),
  .in_ready(in_tri.ready),
  .out_valid(out_hit.valid),
  .out_ready(out_hit.ready),
  .found(out_hit.found),
  .nearest_t(out_hit.nearest_t),
  .cfg_ready(cfg_wr.ready)
);

// ----- tb/sv/ray_triangle_closest_hit_tb.sv -----
`timescale 1ns / 1ps
module ray_triangle_closest_hit_tb;

  localparam int FB = 16;
  localparam longint LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] v[9];
    logic fin;
  } tri_t;

  typedef struct {
    logic found;
    logic [rtch_pkg::TW-1:0] t;
  } hit_t;

  class hit_scoreboard;
    longint ray[6];
    logic [rtch_pkg::TW-1:0] best;
    logic any;
    hit_t pending[$];
    int errors;

    function new();
      ray = '{0, 0, 0, 0, 0, -65536};
      best = rtch_pkg::T_NONE;
      any = 0;
      errors = 0;
    endfunction

    function void set_reg(rtch_pkg::cfg_idx_t idx, logic [31:0] d);
      ray[idx] = longint'($signed(d));
    endfunction

    function longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint fmul(longint a, longint b);
      return (a * b) >>> FB;
    endfunction

    function void xprod(longint p[3], longint r[3], output longint o[3]);
      o[0] = sat(fmul(p[1], r[2]) - fmul(p[2], r[1]));
      o[1] = sat(fmul(p[2], r[0]) - fmul(p[0], r[2]));
      o[2] = sat(fmul(p[0], r[1]) - fmul(p[1], r[0]));
    endfunction

    function longint dprod(longint p[3], longint r[3]);
      return sat(fmul(p[0], r[0]) + fmul(p[1], r[1]) + fmul(p[2], r[2]));
    endfunction

    function void note_tri(tri_t tr);
      longint a, b, c, s[3], e1[3], e2[3], h[3], q[3], d[3];
      longint det, u, v, t, one;
      hit_t r;
      one = 64'sd1 << FB;
      for (int i = 0; i < 3; i++) begin
        a = tr.v[i]; b = tr.v[3+i]; c = tr.v[6+i];
        e1[i] = sat(b - a); e2[i] = sat(c - a); s[i] = sat(ray[i] - a);
        d[i] = ray[3+i];
      end
      xprod(d, e2, h);
      det = dprod(e1, h);
      if (det != 0) begin
        u = (dprod(s, h) * one) / det;
        if (u >= 0 && u <= one) begin
          xprod(s, e1, q);
          v = (dprod(d, q) * one) / det;
          if (v >= 0 && u + v <= one) begin
            t = (dprod(e2, q) * one) / det;
            if (t > 0) begin
              if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
              if (t[rtch_pkg::TW-1:0] < best) begin
                best = t[rtch_pkg::TW-1:0];
                any = 1;
              end
            end
          end
        end
      end
      if (tr.fin) begin
        r.found = any;
        r.t = any ? best : rtch_pkg::T_NONE;
        pending.insert(pending.size(), r);
        best = rtch_pkg::T_NONE;
        any = 0;
      end
    endfunction

    function void check_hit(logic f, logic [rtch_pkg::TW-1:0] t);
      hit_t e;
      if (pending.size() == 0) begin
        $error("unexpected result found=%0d nearest_t=%h", f, t);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (f !== e.found) begin
        $error("found: expected %0d actual %0d", e.found, f);
        errors++;
      end
      if (t !== e.t) begin
        $error("nearest_t: expected %h actual %h", e.t, t);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  rtch_tri_if in_tri();
  rtch_hit_if out_hit();
  rtch_cfg_if cfg_wr();

  ray_triangle_closest_hit #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .in_tri(in_tri.sink), .out_hit(out_hit.source),
    .cfg_wr(cfg_wr.sink)
  );

  hit_scoreboard sb;
  longint cycles;
  bit calm;
  bit hold_long;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_hit.valid && out_hit.ready) sb.check_hit(out_hit.found, out_hit.nearest_t);
  end

  initial begin
    int n;
    out_hit.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_hit.ready <= 0;
        repeat (400) @(negedge clk);
        hold_long = 0;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_hit.ready <= 0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_hit.ready <= 1;
      end
    end
  end

  task automatic cfg_write(rtch_pkg::cfg_idx_t idx, logic [31:0] d);
    @(negedge clk);
    cfg_wr.valid <= 1;
    cfg_wr.index <= idx;
    cfg_wr.data <= d;
    @(posedge clk iff cfg_wr.ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_wr.valid <= 0;
  endtask

  task automatic send_tri(tri_t tr);
    int n;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 5);
      in_tri.valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_tri.valid <= 1;
    {in_tri.a_x, in_tri.a_y, in_tri.a_z} <= {tr.v[0], tr.v[1], tr.v[2]};
    {in_tri.b_x, in_tri.b_y, in_tri.b_z} <= {tr.v[3], tr.v[4], tr.v[5]};
    {in_tri.c_x, in_tri.c_y, in_tri.c_z} <= {tr.v[6], tr.v[7], tr.v[8]};
    in_tri.final_tri <= tr.fin;
    @(posedge clk iff in_tri.ready);
    sb.note_tri(tr);
    @(negedge clk);
    in_tri.valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
      default: return $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
    endcase
  endfunction

  function automatic tri_t make_tri(int mode, bit fin);
    tri_t tr;
    for (int i = 0; i < 9; i++) tr.v[i] = rand_coord(mode);
    if (mode == 2) begin
      tr.v[2] = -$signed($urandom_range(65536, 20 * 65536));
      tr.v[5] = tr.v[2] + $signed($urandom_range(0, 8192)) - 4096;
      tr.v[8] = tr.v[2] + $signed($urandom_range(0, 8192)) - 4096;
      tr.v[0] = -$signed($urandom_range(0, 3 * 65536));
      tr.v[1] = -$signed($urandom_range(0, 3 * 65536));
      tr.v[3] = $signed($urandom_range(0, 3 * 65536)); tr.v[4] = tr.v[1];
      tr.v[6] = tr.v[0]; tr.v[7] = $signed($urandom_range(0, 3 * 65536));
    end
    tr.fin = fin;
    return tr;
  endfunction

  initial begin
    tri_t tr;
    int mode, len;
    sb = new();
    cycles = 0;
    calm = 0;
    hold_long = 0;
    rst_n = 0;
    in_tri.valid = 0;
    {in_tri.a_x, in_tri.a_y, in_tri.a_z, in_tri.b_x, in_tri.b_y, in_tri.b_z} = '0;
    {in_tri.c_x, in_tri.c_y, in_tri.c_z} = '0;
    in_tri.final_tri = 0;
    cfg_wr.valid = 0;
    cfg_wr.index = rtch_pkg::CFG_ORIGIN_X;
    cfg_wr.data = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed, default ray along -z
    tr = make_tri(2, 1); send_tri(tr);
    tr = make_tri(2, 0); send_tri(tr);
    tr = make_tri(2, 0); send_tri(tr);
    tr = make_tri(2, 1); send_tri(tr);
    // parallel: triangle in a plane containing the ray
    tr.v = '{0, 0, -65536, 65536, 0, -65536, 0, 0, -131072}; tr.fin = 1; send_tri(tr);
    // behind
    tr.v = '{-65536, -65536, 65536, 65536, -65536, 65536, -65536, 65536, 65536};
    tr.fin = 1; send_tri(tr);
    // outside
    tr.v = '{65536, 65536, -65536, 131072, 65536, -65536, 65536, 131072, -65536};
    tr.fin = 1; send_tri(tr);
    // extremes
    tr.v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
    tr.fin = 1; send_tri(tr);
    tr.v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff};
    tr.fin = 0; send_tri(tr);
    tr.v = '{default: 32'hffffffff}; tr.fin = 1; send_tri(tr);
    // far hit: tiny direction makes t saturate
    drain();
    cfg_write(rtch_pkg::CFG_DIR_Z, 32'hffffffff);
    tr = make_tri(2, 1); send_tri(tr);
    tr = make_tri(2, 1); send_tri(tr);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          for (int i = 0; i < 6; i++) cfg_write(rtch_pkg::cfg_idx_t'(i), 0);
          cfg_write(rtch_pkg::CFG_DIR_Z, -65536);
        end
        1: begin
          cfg_write(rtch_pkg::CFG_ORIGIN_X, 32'h7fffffff);
          cfg_write(rtch_pkg::CFG_ORIGIN_Y, 32'h80000000);
          cfg_write(rtch_pkg::CFG_ORIGIN_Z, 32'h7fffffff);
          cfg_write(rtch_pkg::CFG_DIR_X, 32'h80000000);
          cfg_write(rtch_pkg::CFG_DIR_Y, 32'h7fffffff);
          cfg_write(rtch_pkg::CFG_DIR_Z, 32'h80000000);
        end
        5: begin
          for (int i = 0; i < 6; i++) cfg_write(rtch_pkg::cfg_idx_t'(i), 0);
          cfg_write(rtch_pkg::CFG_DIR_Z, -65536);
          calm = 1;
        end
        default: begin
          for (int i = 0; i < 3; i++) cfg_write(rtch_pkg::cfg_idx_t'(i), rand_coord(2) >>> 2);
          cfg_write(rtch_pkg::CFG_DIR_X, $signed($urandom_range(0, 16384)) - 8192);
          cfg_write(rtch_pkg::CFG_DIR_Y, $signed($urandom_range(0, 16384)) - 8192);
          cfg_write(rtch_pkg::CFG_DIR_Z, -$signed($urandom_range(32768, 131072)));
        end
      endcase
      if (phase == 2) hold_long = 1;
      for (int k = 0; k < 210;) begin
        len = $urandom_range(1, 6);
        mode = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 1) : 2;
        for (int j = 0; j < len; j++) begin
          tr = make_tri(mode, j == len - 1);
          send_tri(tr);
          k++;
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- ray_triangle_closest_hit.f -----
+incdir+sv
sv/rtch_pkg.sv
sv/rtch_if.sv
sv/ray_triangle_closest_hit.sv
sv/rtch_chk.sv
tb/sv/ray_triangle_closest_hit_tb.sv
